[hdl/hwsf_pkg.sv]
`timescale 1ns / 1ps

package hwsf_pkg;

  // matrix storage is laid out for the largest grid, row stride fixed
  localparam int MAXDIM = 12;
  localparam int CELLS  = MAXDIM * MAXDIM;

  localparam logic [11:0] WHEEL     = 12'd1536;
  localparam logic [5:0]  SPEED_MIN = 6'd1;
  localparam logic [5:0]  SPEED_MAX = 6'd40;
  localparam logic [7:0]  ZOOM_MIN  = 8'd1;
  localparam logic [7:0]  ZOOM_MAX  = 8'd250;
  localparam logic [7:0]  ZOOM_STEP = 8'd5;

  localparam logic [5:0]  SPEED_RST = 6'd4;
  localparam logic [7:0]  ZOOM_RST  = 8'd20;

  // input kinds carried on tuser
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_BUTTON = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  // button numbers
  localparam logic [7:0] BTN_SLOWER   = 8'd1;
  localparam logic [7:0] BTN_FASTER   = 8'd2;
  localparam logic [7:0] BTN_ZOOM_OUT = 8'd3;
  localparam logic [7:0] BTN_ZOOM_IN  = 8'd4;

  // register indexes, taken from paddr[2]
  localparam logic REG_INIT_SPEED = 1'b0;
  localparam logic REG_INIT_ZOOM  = 1'b1;

  localparam int IN_W  = 16;
  localparam int OUT_W = 296;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_ADV,
    ST_ADV_DRAIN,
    ST_ROW_RD,
    ST_ROW_WAIT
  } ctrl_state_t;

  typedef struct packed {
    logic [5:0] speed;
    logic [7:0] zoom;
    logic       mirror;
    logic       reverse;
  } mode_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] button;
    logic [7:0] held;
  } btn_evt_t;

  typedef struct packed {
    logic       cap_vld;
    logic [3:0] cap_col;
    logic       load;
    logic [3:0] row_idx;
    logic       last;
  } row_ctl_t;

  // six-segment rainbow wheel, R in the high byte
  function automatic logic [23:0] hue_rgb(input logic [10:0] p);
    logic [7:0] i;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    i = p[7:0];
    case (p[10:8])
      3'd0: begin r = 8'd255;     g = i;          b = 8'd0;       end
      3'd1: begin r = 8'd255 - i; g = 8'd255;     b = 8'd0;       end
      3'd2: begin r = 8'd0;       g = 8'd255;     b = i;          end
      3'd3: begin r = 8'd0;       g = 8'd255 - i; b = 8'd255;     end
      3'd4: begin r = i;          g = 8'd0;       b = 8'd255;     end
      3'd5: begin r = 8'd255;     g = 8'd0;       b = 8'd255 - i; end
      default: begin r = 8'd0;    g = 8'd0;       b = 8'd0;       end
    endcase
    return {r, g, b};
  endfunction

endpackage

[hdl/hwsf_phase_ram.sv]
`timescale 1ns / 1ps

module hwsf_phase_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [10:0] wdata,
  input  logic        re,
  input  logic [7:0]  raddr,
  output logic [10:0] rdata
);
  import hwsf_pkg::*;

  logic [10:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/hwsf_regs.sv]
`timescale 1ns / 1ps

module hwsf_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  hwsf_pkg::btn_evt_t btn,
  output hwsf_pkg::mode_t   mode,
  output logic              rebuild
);
  import hwsf_pkg::*;

  logic [5:0] init_speed;
  logic [7:0] init_zoom;
  logic [5:0] speed;
  logic [5:0] speed_next;
  logic [7:0] zoom;
  logic [7:0] zoom_next;
  logic       mirror;
  logic       mirror_next;
  logic       reverse;
  logic       reverse_next;
  logic       wr;
  logic [8:0] zoom_up;

  function automatic logic [5:0] sat_speed(input logic [5:0] v);
    if (v < SPEED_MIN) return SPEED_MIN;
    if (v > SPEED_MAX) return SPEED_MAX;
    return v;
  endfunction

  function automatic logic [7:0] sat_zoom(input logic [7:0] v);
    if (v < ZOOM_MIN) return ZOOM_MIN;
    if (v > ZOOM_MAX) return ZOOM_MAX;
    return v;
  endfunction

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INIT_ZOOM) ? {24'd0, init_zoom} : {26'd0, init_speed};
  assign zoom_up = {1'b0, zoom} + {1'b0, ZOOM_STEP};

  always_comb begin
    speed_next   = speed;
    zoom_next    = zoom;
    mirror_next  = mirror;
    reverse_next = reverse;
    rebuild      = 1'b0;
    if (btn.vld) begin
      case (btn.button)
        BTN_SLOWER: begin
          if (btn.held[1]) begin
            mirror_next = !mirror;
            rebuild     = 1'b1;
          end else begin
            speed_next = (speed <= 6'd2) ? SPEED_MIN : speed - 6'd1;
          end
        end
        BTN_FASTER: begin
          speed_next = (speed + 6'd1 >= SPEED_MAX) ? SPEED_MAX : speed + 6'd1;
        end
        BTN_ZOOM_OUT: begin
          if (btn.held[3]) begin
            reverse_next = !reverse;
          end else if (zoom <= 8'd6) begin
            zoom_next = ZOOM_MIN;
          end else begin
            zoom_next = zoom - ZOOM_STEP;
            rebuild   = 1'b1;
          end
        end
        BTN_ZOOM_IN: begin
          if (zoom_up >= {1'b0, ZOOM_MAX}) begin
            zoom_next = ZOOM_MAX;
          end else begin
            zoom_next = zoom_up[7:0];
            rebuild   = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_speed <= SPEED_RST;
      init_zoom  <= ZOOM_RST;
      speed      <= sat_speed(SPEED_RST);
      zoom       <= sat_zoom(ZOOM_RST);
      mirror     <= 1'b0;
      reverse    <= 1'b0;
    end else begin
      speed   <= speed_next;
      zoom    <= zoom_next;
      mirror  <= mirror_next;
      reverse <= reverse_next;
      if (wr) begin
        if (paddr[2] == REG_INIT_ZOOM) begin
          init_zoom <= pwdata[7:0];
          zoom      <= sat_zoom(pwdata[7:0]);
        end else begin
          init_speed <= pwdata[5:0];
          speed      <= sat_speed(pwdata[5:0]);
        end
      end
    end
  end

  assign mode = '{speed: speed, zoom: zoom, mirror: mirror, reverse: reverse};

endmodule

[hdl/hwsf_row.sv]
`timescale 1ns / 1ps

module hwsf_row #(
  parameter int GRID_SIZE = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  hwsf_pkg::row_ctl_t        ctl,
  input  logic [10:0]               phase,
  output logic                      out_free,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [hwsf_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import hwsf_pkg::*;

  logic [23:0]      rowbuf [MAXDIM];
  logic [OUT_W-1:0] packed_row;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (ctl.cap_vld) begin
      rowbuf[ctl.cap_col] <= hue_rgb(phase);
    end
  end

  // columns past the grid read as black
  always_comb begin
    packed_row = '0;
    packed_row[3:0] = ctl.row_idx;
    for (int k = 0; k < MAXDIM / 2; k++) begin
      if (2 * k < GRID_SIZE) begin
        packed_row[4 + 48 * k + 24 +: 24] = rowbuf[2 * k];
      end
      if (2 * k + 1 < GRID_SIZE) begin
        packed_row[4 + 48 * k +: 24] = rowbuf[2 * k + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      m_tdata <= packed_row;
      m_tlast <= ctl.last;
    end
  end

endmodule

[hdl/hwsf_ctrl.sv]
`timescale 1ns / 1ps

module hwsf_ctrl #(
  parameter int GRID_SIZE = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [hwsf_pkg::IN_W-1:0] s_tdata,
  input  logic [1:0]               s_tuser,
  input  hwsf_pkg::mode_t          mode,
  input  logic                     rebuild,
  output hwsf_pkg::btn_evt_t       btn,
  output logic                     we,
  output logic [7:0]               waddr,
  output logic [10:0]              wdata,
  output logic                     re,
  output logic [7:0]               raddr,
  input  logic [10:0]              rdata,
  output hwsf_pkg::row_ctl_t       row_ctl,
  input  logic                     out_free
);
  import hwsf_pkg::*;

  localparam int HALF = (GRID_SIZE + 1) / 2;
  localparam logic [3:0] LAST      = 4'(GRID_SIZE - 1);
  localparam logic [3:0] HALF_LAST = 4'(HALF - 1);
  localparam logic [3:0] Q_OFF     = 4'(GRID_SIZE - HALF);
  localparam logic [4:0] GRID_W    = 5'(GRID_SIZE);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic [3:0]  y;
  logic [3:0]  y_next;
  logic [3:0]  x;
  logic [3:0]  x_next;
  logic        adv_pend;
  logic        adv_pend_next;
  logic        row_pend;
  logic        row_pend_next;
  logic [3:0]  col_q;
  logic [7:0]  addr_q;

  logic [3:0]  lim_last;
  logic [3:0]  qy;
  logic [3:0]  qx;
  logic [4:0]  diag;
  logic [12:0] prod;
  logic [10:0] build_val;
  logic [11:0] fwd_sum;
  logic [10:0] adv_val;

  function automatic logic [7:0] cell_addr(input logic [3:0] row, input logic [3:0] col);
    return 8'({row, 3'b000}) + 8'({row, 2'b00}) + 8'(col);
  endfunction

  assign lim_last = mode.mirror ? HALF_LAST : LAST;

  // quadrant reflection for mirror mode
  assign qy = mode.mirror ? ((y < 4'(HALF)) ? y : LAST - y) : y;
  assign qx = mode.mirror ? ((x < 4'(HALF)) ? HALF_LAST - x : x - Q_OFF) : x;

  // rebuild value ((x + grid - y) * zoom) mod wheel, product stays below four turns
  assign diag = 5'(x) + GRID_W - 5'(y);
  assign prod = 13'(diag) * 13'(mode.zoom);
  always_comb begin
    if (prod >= 13'd4608) begin
      build_val = 11'(prod - 13'd4608);
    end else if (prod >= 13'd3072) begin
      build_val = 11'(prod - 13'd3072);
    end else if (prod >= 13'd1536) begin
      build_val = 11'(prod - 13'd1536);
    end else begin
      build_val = prod[10:0];
    end
  end

  // phase step with wrap in either direction
  assign fwd_sum = {1'b0, rdata} + 12'(mode.speed);
  always_comb begin
    if (mode.reverse) begin
      if (rdata >= 11'(mode.speed)) begin
        adv_val = rdata - 11'(mode.speed);
      end else begin
        adv_val = 11'({1'b0, rdata} + WHEEL - 12'(mode.speed));
      end
    end else if (fwd_sum >= WHEEL) begin
      adv_val = 11'(fwd_sum - WHEEL);
    end else begin
      adv_val = fwd_sum[10:0];
    end
  end

  always_comb begin
    state_next    = state;
    y_next        = y;
    x_next        = x;
    adv_pend_next = 1'b0;
    row_pend_next = 1'b0;
    s_tready      = 1'b0;
    btn           = '{vld: 1'b0, button: s_tdata[7:0], held: s_tdata[15:8]};
    re            = 1'b0;
    raddr         = cell_addr(y, x);
    we            = 1'b0;
    waddr         = cell_addr(y, x);
    wdata         = build_val;
    row_ctl       = '{cap_vld: row_pend, cap_col: col_q, load: 1'b0, row_idx: y,
                      last: (y == LAST)};

    // write-back of the previous advance read
    if (adv_pend) begin
      we    = 1'b1;
      waddr = addr_q;
      wdata = adv_val;
    end

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        y_next   = 4'd0;
        x_next   = 4'd0;
        if (s_tvalid) begin
          case (s_tuser)
            FUNC_TICK:   state_next = ST_ADV;
            FUNC_START:  state_next = ST_BUILD;
            FUNC_BUTTON: begin
              btn.vld = 1'b1;
              if (rebuild) begin
                state_next = ST_BUILD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_BUILD: begin
        we = 1'b1;
        if (x == LAST) begin
          x_next = 4'd0;
          if (y == LAST) begin
            state_next = ST_IDLE;
          end else begin
            y_next = y + 4'd1;
          end
        end else begin
          x_next = x + 4'd1;
        end
      end
      ST_ADV: begin
        re            = 1'b1;
        adv_pend_next = 1'b1;
        if (x == lim_last) begin
          x_next = 4'd0;
          if (y == lim_last) begin
            y_next     = 4'd0;
            state_next = ST_ADV_DRAIN;
          end else begin
            y_next = y + 4'd1;
          end
        end else begin
          x_next = x + 4'd1;
        end
      end
      ST_ADV_DRAIN: begin
        state_next = ST_ROW_RD;
      end
      ST_ROW_RD: begin
        re            = 1'b1;
        raddr         = cell_addr(qy, qx);
        row_pend_next = 1'b1;
        if (x == LAST) begin
          state_next = ST_ROW_WAIT;
        end else begin
          x_next = x + 4'd1;
        end
      end
      ST_ROW_WAIT: begin
        if (!row_pend && out_free) begin
          row_ctl.load = 1'b1;
          x_next       = 4'd0;
          if (y == LAST) begin
            state_next = ST_IDLE;
          end else begin
            y_next     = y + 4'd1;
            state_next = ST_ROW_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      y        <= 4'd0;
      x        <= 4'd0;
      adv_pend <= 1'b0;
      row_pend <= 1'b0;
    end else begin
      state    <= state_next;
      y        <= y_next;
      x        <= x_next;
      adv_pend <= adv_pend_next;
      row_pend <= row_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    col_q  <= x;
    addr_q <= raddr;
  end

endmodule

[hdl/hue_wheel_scroll_frame_generator.sv]
`timescale 1ns / 1ps

// hue wheel scroll frame generator for a GRID_SIZE x GRID_SIZE led matrix
//
// input channel s_*: one beat per command, tuser carries the kind (frame
// tick, button event, start), tdata the button number and held mask.
// output channel m_*: a frame tick yields GRID_SIZE beats, one per row,
// row index in the low nibble of tdata, tlast on the last row.
// apb port: init_speed at 0x0, init_zoom at 0x4; a write also reloads the
// working speed or zoom, saturated into range. write only while idle.
//
// work per input beat, paced by the phase memory (one read, one write port):
//   start, or a button that rebuilds: a sweep writing one cell a cycle
//   other button or unused kind:      taken with no further work
//   frame tick: an L x L read-modify-write advance, L = GRID_SIZE, or
//   (GRID_SIZE+1)/2 in mirror mode, a drain step, then GRID_SIZE row reads
// each row's beat is loaded once its reads are done and the output register is free
// reset: speed 4, zoom 20, full grid, forward direction, output empty;
// the phase memory holds nothing useful until a start beat fills it
// a stalled receiver holds the row in the output register; the next row
// waits in the row buffer, and the last row does not block a new command
module hue_wheel_scroll_frame_generator #(
  parameter int GRID_SIZE = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  // slave stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // [7:0] button, [15:8] button_states
  input  logic [hwsf_pkg::IN_W-1:0]  s_tdata,
  // [1:0] func
  input  logic [1:0]                 s_tuser,
  // master stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // [3:0] row_index, [51:4] pixels_0_1, [99:52] pixels_2_3,
  // [147:100] pixels_4_5, [195:148] pixels_6_7, [243:196] pixels_8_9,
  // [291:244] pixels_10_11, [295:292] zero
  output logic [hwsf_pkg::OUT_W-1:0] m_tdata,
  // frame_end
  output logic                       m_tlast,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hwsf_pkg::*;

  mode_t      mode;
  btn_evt_t   btn;
  logic       rebuild;
  row_ctl_t   row_ctl;
  logic       out_free;
  logic       we;
  logic [7:0] waddr;
  logic [10:0] wdata;
  logic       re;
  logic [7:0] raddr;
  logic [10:0] rdata;

  // speed, zoom, mode and direction plus the init registers
  hwsf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .btn     (btn),
    .mode    (mode),
    .rebuild (rebuild)
  );

  // sequencer: rebuild sweep, read-modify-write advance, row readout
  hwsf_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .mode     (mode),
    .rebuild  (rebuild),
    .btn      (btn),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .rdata    (rdata),
    .row_ctl  (row_ctl),
    .out_free (out_free)
  );

  // phase per cell, row stride of twelve
  hwsf_phase_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hue conversion, row buffer and output register
  hwsf_row #(.GRID_SIZE(GRID_SIZE)) u_row (
    .clk      (clk),
    .rst      (rst),
    .ctl      (row_ctl),
    .phase    (rdata),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[hdl/hwsf_checker.sv]
`timescale 1ns / 1ps

module hwsf_checker #(
  parameter int GRID_SIZE = 12
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [hwsf_pkg::OUT_W-1:0] m_tdata,
  input logic                       m_tlast,
  input logic                       pready
);
  import hwsf_pkg::*;

  localparam logic [3:0] LAST = 4'(GRID_SIZE - 1);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("row beat dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("row beat changed while stalled");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[3:0] == LAST)))
    else $error("frame end not on last row");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= LAST))
    else $error("row index past grid");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("apb wait state");

endmodule

bind hue_wheel_scroll_frame_generator hwsf_checker #(.GRID_SIZE(GRID_SIZE)) u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .pready   (pready)
);

[tb/hue_wheel_scroll_frame_generator_tb.sv]
`timescale 1ns / 1ps

module hue_wheel_scroll_frame_generator_tb;
  import hwsf_pkg::*;

  localparam int GRID   = 12;
  localparam int HALF   = (GRID + 1) / 2;
  localparam int STRIDE = MAXDIM;

  // func code the block ignores
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // long enough to cover any rebuild or frame tick work still running after
  // the last row beat has left
  localparam int SETTLE_CYCLES = 400;
  // long receiver hold-off so the row buffer fills and the input stalls
  localparam int HOLD_CYCLES   = 1500;

  // one expected row beat; the corner fields carry a hand-worked value for
  // the top-left pixel of a few directed frames
  typedef struct packed {
    logic             has_corner;
    logic [23:0]      corner;
    logic             last;
    logic [5:0][47:0] px;
    logic [3:0]       row;
  } frame_row_t;

  typedef enum {STEP_BEAT, STEP_WRITE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [1:0]  func;
    logic [7:0]  button;
    logic [7:0]  held;
    logic        reg_idx;
    logic [31:0] value;
    logic        has_corner;
    logic [23:0] corner;
  } plan_step_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic [1:0]          s_tuser = FUNC_TICK;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic                m_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  // typed corner value travelling alongside the command beat
  logic                corner_flag = 1'b0;
  logic [23:0]         corner_rgb = '0;

  // idling knobs, set by the stimulus process
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  bit                  pressure_phase = 1'b0;

  // receiver hold-off, owned by the receiver process
  bit                  hold_done = 1'b0;
  int                  hold_left = 0;

  // predictor state
  logic [10:0]         phase_mem [0:GRID*STRIDE-1];
  logic [5:0]          cur_speed;
  logic [7:0]          cur_zoom;
  logic                mirror_on;
  logic                reverse_on;
  frame_row_t          expected_rows[$];

  int                  errors = 0;
  int                  rows_checked = 0;
  int                  n_ticks = 0;
  int                  n_buttons = 0;
  int                  n_starts = 0;
  int                  n_ignored = 0;
  int                  n_writes = 0;
  int                  mirror_toggles = 0;
  int                  reverse_toggles = 0;

  hue_wheel_scroll_frame_generator #(.GRID_SIZE(GRID)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // diagonal ramp: cell (x,y) gets (x + GRID - y) * zoom round the wheel
  function void rebuild_phases();
    for (int y = 0; y < GRID; y++) begin
      for (int x = 0; x < GRID; x++) begin
        phase_mem[y*STRIDE + x] = 11'((x + GRID - y) * int'(cur_zoom) % int'(WHEEL));
      end
    end
  endfunction

  // six 256-step segments; 255 - i is the bitwise inverse of i
  function automatic logic [23:0] wheel_colour(logic [10:0] p);
    logic [7:0] f;
    f = p[7:0];
    case (p[10:8])
      3'd0:    return {8'hFF, f,     8'h00};
      3'd1:    return {~f,    8'hFF, 8'h00};
      3'd2:    return {8'h00, 8'hFF, f};
      3'd3:    return {8'h00, ~f,    8'hFF};
      3'd4:    return {f,     8'h00, 8'hFF};
      3'd5:    return {8'hFF, 8'h00, ~f};
      default: return 24'h0;
    endcase
  endfunction

  // mirror mode folds every cell back onto the top-left quadrant, with the
  // left half reflected column-wise
  function automatic logic [23:0] cell_colour(int r, int c);
    int qr;
    int qc;
    if (!mirror_on) return wheel_colour(phase_mem[r*STRIDE + c]);
    qr = (r < HALF) ? r : GRID - 1 - r;
    qc = (c < HALF) ? HALF - 1 - c : c - (GRID - HALF);
    return wheel_colour(phase_mem[qr*STRIDE + qc]);
  endfunction

  function void advance_and_render(logic with_corner, logic [23:0] corner);
    int lim;
    int p;
    frame_row_t fr;
    lim = mirror_on ? HALF : GRID;
    for (int y = 0; y < lim; y++) begin
      for (int x = 0; x < lim; x++) begin
        p = int'(phase_mem[y*STRIDE + x]);
        if (reverse_on) begin
          p = (p >= int'(cur_speed)) ? p - int'(cur_speed)
                                     : p + int'(WHEEL) - int'(cur_speed);
        end else begin
          p = p + int'(cur_speed);
          if (p >= int'(WHEEL)) p = p - int'(WHEEL);
        end
        phase_mem[y*STRIDE + x] = 11'(p);
      end
    end
    for (int r = 0; r < GRID; r++) begin
      fr.row = 4'(r);
      for (int k = 0; k < 6; k++) begin
        fr.px[k] = {cell_colour(r, 2*k), cell_colour(r, 2*k + 1)};
      end
      fr.last       = (r == GRID - 1);
      fr.has_corner = with_corner && (r == 0);
      fr.corner     = corner;
      expected_rows.push_back(fr);
    end
  endfunction

  function void press_button(logic [7:0] button, logic [7:0] held);
    case (button)
      BTN_SLOWER: begin
        if (held[1]) begin
          rebuild_phases();
          mirror_on = !mirror_on;
          mirror_toggles++;
        end else begin
          cur_speed = (cur_speed <= 6'd2) ? SPEED_MIN : cur_speed - 6'd1;
        end
      end
      BTN_FASTER: begin
        cur_speed = (int'(cur_speed) + 1 >= int'(SPEED_MAX)) ? SPEED_MAX
                                                            : cur_speed + 6'd1;
      end
      BTN_ZOOM_OUT: begin
        if (held[3]) begin
          reverse_on = !reverse_on;
          reverse_toggles++;
        end else if (cur_zoom <= 8'd6) begin
          cur_zoom = ZOOM_MIN;
        end else begin
          cur_zoom = cur_zoom - ZOOM_STEP;
          rebuild_phases();
        end
      end
      BTN_ZOOM_IN: begin
        if (int'(cur_zoom) + int'(ZOOM_STEP) >= int'(ZOOM_MAX)) begin
          cur_zoom = ZOOM_MAX;
        end else begin
          cur_zoom = cur_zoom + ZOOM_STEP;
          rebuild_phases();
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  function void apply_command(logic [1:0] func, logic [7:0] button, logic [7:0] held);
    case (func)
      FUNC_TICK: begin
        n_ticks++;
        advance_and_render(corner_flag, corner_rgb);
      end
      FUNC_BUTTON: begin
        n_buttons++;
        press_button(button, held);
      end
      FUNC_START: begin
        n_starts++;
        rebuild_phases();
      end
      default: n_ignored++;
    endcase
  endfunction

  // a register write reloads the working value, saturated into range
  function void load_register(logic idx, logic [31:0] val);
    if (idx == REG_INIT_SPEED) begin
      cur_speed = (val[5:0] < SPEED_MIN) ? SPEED_MIN :
                  (val[5:0] > SPEED_MAX) ? SPEED_MAX : val[5:0];
    end else begin
      cur_zoom = (val[7:0] < ZOOM_MIN) ? ZOOM_MIN :
                 (val[7:0] > ZOOM_MAX) ? ZOOM_MAX : val[7:0];
    end
  endfunction

  function void check_field(string what, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // scoreboard: check the outgoing row first, then fold in whatever the
  // block accepted at the same edge
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    frame_row_t want;
    if (rst) begin
      cur_speed  = SPEED_RST;
      cur_zoom   = ZOOM_RST;
      mirror_on  = 1'b0;
      reverse_on = 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t row beat with nothing expected: row %0d, expected none, got %h",
                   $time, m_tdata[3:0], m_tdata);
          errors++;
        end else begin
          want = expected_rows.pop_front();
          check_field("row_index", 48'(want.row), 48'(m_tdata[3:0]));
          for (int k = 0; k < 6; k++) begin
            check_field($sformatf("pixels_%0d_%0d", 2*k, 2*k + 1), want.px[k],
                        m_tdata[4 + 48*k +: 48]);
          end
          check_field("frame_end", 48'(want.last), 48'(m_tlast));
          if (want.has_corner) begin
            check_field("top-left pixel", 48'(want.corner), 48'(m_tdata[51:28]));
          end
          rows_checked++;
        end
      end
      if (psel && penable && pwrite && pready) load_register(paddr[2], pwdata);
      if (s_tvalid && s_tready) apply_command(s_tuser, s_tdata[7:0], s_tdata[15:8]);
    end
  end

  // ---------------------------------------------------------------------
  // receiver: random back-pressure, plus one long hold-off in the last phase
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : receiver
    if (pressure_phase && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // sender and configuration tasks
  // ---------------------------------------------------------------------

  // returns at the edge where the beat was taken, s_tvalid still high
  task automatic send_beat(logic [1:0] func, logic [7:0] button, logic [7:0] held,
                           logic with_corner, logic [23:0] corner);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tuser     <= func;
    s_tdata     <= {held, button};
    corner_flag <= with_corner;
    corner_rgb  <= corner;
    do @(posedge clk); while (!s_tready);
  endtask

  // wait until every expected row has left and any rebuild has finished;
  // one edge first so the scoreboard has taken the last accepted beat
  task automatic drain_block();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_writes++;
  endtask

  function automatic plan_step_t cmd(logic [1:0] f, logic [7:0] b, logic [7:0] h);
    plan_step_t s;
    s.kind       = STEP_BEAT;
    s.func       = f;
    s.button     = b;
    s.held       = h;
    s.reg_idx    = 1'b0;
    s.value      = '0;
    s.has_corner = 1'b0;
    s.corner     = '0;
    return s;
  endfunction

  function automatic plan_step_t tick_with_corner(logic [23:0] rgb);
    plan_step_t s;
    s = cmd(FUNC_TICK, 8'h00, 8'h00);
    s.has_corner = 1'b1;
    s.corner     = rgb;
    return s;
  endfunction

  function automatic plan_step_t reg_write(logic idx, logic [31:0] val);
    plan_step_t s;
    s = cmd(FUNC_TICK, 8'h00, 8'h00);
    s.kind    = STEP_WRITE;
    s.reg_idx = idx;
    s.value   = val;
    return s;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    plan_step_t plan[$];
    int counted;
    int pick;
    logic [7:0] btn;

    // default speed 4, zoom 20: the top-left cell starts at 12*20 = 240
    plan.push_back(cmd(FUNC_START, 8'h00, 8'h00));
    plan.push_back(tick_with_corner(24'hFFF400));        // 244, first segment
    plan.push_back(cmd(FUNC_TICK, 8'hFF, 8'hFF));        // tick ignores its data
    plan.push_back(cmd(FUNC_BUTTON, 8'h00, 8'hFF));      // button 0 does nothing
    plan.push_back(cmd(FUNC_BUTTON, 8'hFF, 8'hFF));      // nor does button 255
    plan.push_back(cmd(FUNC_UNUSED, 8'hFF, 8'hFF));      // unused kind, no rows
    plan.push_back(cmd(FUNC_BUTTON, BTN_SLOWER, 8'h02)); // rebuild, mirror on
    plan.push_back(cmd(FUNC_TICK, 8'h00, 8'h00));
    plan.push_back(cmd(FUNC_BUTTON, BTN_ZOOM_OUT, 8'h08)); // reverse on
    plan.push_back(cmd(FUNC_TICK, 8'h00, 8'h00));
    plan.push_back(cmd(FUNC_BUTTON, BTN_SLOWER, 8'h00));
    plan.push_back(cmd(FUNC_BUTTON, BTN_FASTER, 8'h00));
    plan.push_back(cmd(FUNC_BUTTON, BTN_ZOOM_IN, 8'h00));  // zoom 25, rebuild
    plan.push_back(cmd(FUNC_BUTTON, BTN_ZOOM_OUT, 8'hF7)); // bit 3 clear: zoom 20
    plan.push_back(cmd(FUNC_BUTTON, BTN_SLOWER, 8'hFF));   // rebuild, mirror off
    plan.push_back(cmd(FUNC_TICK, 8'h00, 8'h00));
    // top of the ranges: 63 saturates to 40, 255 to 250
    plan.push_back(reg_write(REG_INIT_SPEED, 32'd63));
    plan.push_back(reg_write(REG_INIT_ZOOM, 32'd255));
    plan.push_back(cmd(FUNC_START, 8'h00, 8'h00));
    plan.push_back(tick_with_corner(24'hFF006F));          // 3000 mod 1536 - 40
    plan.push_back(cmd(FUNC_BUTTON, BTN_FASTER, 8'h00));   // stays at 40
    plan.push_back(cmd(FUNC_BUTTON, BTN_ZOOM_IN, 8'h00));  // stays at 250
    plan.push_back(cmd(FUNC_TICK, 8'h00, 8'h00));
    // bottom of the ranges: 0 saturates to 1
    plan.push_back(reg_write(REG_INIT_SPEED, 32'd0));
    plan.push_back(reg_write(REG_INIT_ZOOM, 32'd0));
    plan.push_back(cmd(FUNC_START, 8'h00, 8'h00));
    plan.push_back(tick_with_corner(24'hFF0B00));          // 12 - 1, reversed
    plan.push_back(cmd(FUNC_BUTTON, BTN_SLOWER, 8'h00));   // stays at 1
    plan.push_back(cmd(FUNC_BUTTON, BTN_ZOOM_OUT, 8'h00)); // stays at 1
    plan.push_back(cmd(FUNC_TICK, 8'h00, 8'h00));          // cell at 0 wraps to 1535

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 15;
    rx_idle_pct = 81;
    foreach (plan[i]) begin
      if (plan[i].kind == STEP_WRITE) begin
        drain_block();
        apb_write(plan[i].reg_idx, plan[i].value);
      end else begin
        send_beat(plan[i].func, plan[i].button, plan[i].held,
                  plan[i].has_corner, plan[i].corner);
      end
    end

    // three random phases: sender light / receiver heavy, the reverse, then
    // no idling at all with one long receiver hold-off at its start
    for (int ph = 0; ph < 3; ph++) begin
      drain_block();
      apb_write(REG_INIT_SPEED, 32'($urandom_range(0, 63)));
      apb_write(REG_INIT_ZOOM, 32'($urandom_range(0, 255)));
      case (ph)
        0: begin
          tx_idle_pct = 15;
          rx_idle_pct = 81;
        end
        1: begin
          tx_idle_pct = 81;
          rx_idle_pct = 15;
        end
        default: begin
          tx_idle_pct    = 0;
          rx_idle_pct    = 0;
          pressure_phase = 1'b1;
        end
      endcase
      counted = 0;
      while (counted < 25) begin
        pick = $urandom_range(0, 99);
        // open the hold-off with a burst of ticks so rows pile up
        if (ph == 2 && counted < 4) pick = 0;
        if (pick < 45) begin
          send_beat(FUNC_TICK, 8'($urandom), 8'($urandom), 1'b0, 24'h0);
          counted++;
        end else if (pick < 85) begin
          send_beat(FUNC_BUTTON, 8'($urandom_range(1, 4)), 8'($urandom), 1'b0, 24'h0);
          counted++;
        end else if (pick < 93) begin
          btn = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(5, 255));
          send_beat(FUNC_BUTTON, btn, 8'($urandom), 1'b0, 24'h0);
        end else if (pick < 97) begin
          send_beat(FUNC_START, 8'($urandom), 8'($urandom), 1'b0, 24'h0);
          counted++;
        end else begin
          send_beat(FUNC_UNUSED, 8'($urandom), 8'($urandom), 1'b0, 24'h0);
        end
      end
    end

    drain_block();

    $display("covered %0d frame ticks, %0d button events, %0d starts, %0d ignored beats",
             n_ticks, n_buttons, n_starts, n_ignored);
    $display("%0d row beats checked, %0d register writes, %0d mirror and %0d reverse toggles",
             rows_checked, n_writes, mirror_toggles, reverse_toggles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
